// ===== rtl/core/lightmap_bilinear_sampler_core_macros.svh =====
// ----------------------------------------------------------------------------
// Lightmap sampler assertion macros
// Shared concurrent assertion forms for the sampler core modules.
// ----------------------------------------------------------------------------
`ifndef LIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH
`define LIGHTMAP_BILINEAR_SAMPLER_CORE_MACROS_SVH

// same-cycle implication
`define LBS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lbs assertion failed");

// next-cycle implication
`define LBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lbs assertion failed");

`endif

// ===== rtl/core/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Lightmap sampler package
// Widths, limits, shared types and the interpolation step function.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int MAX_LAYERS_DEF = 4;

    localparam int TEXEL_W     = 24;
    localparam int CH_W        = 8;
    localparam int STYLE_W     = 10;
    localparam int FRAC_W      = 4;
    localparam int SUM_W       = 12;
    localparam int LEVEL_W     = 12;
    localparam int NUM_CORNERS = 4;
    localparam int NUM_CH      = 3;
    localparam int NUM_SUMS    = NUM_CORNERS * NUM_CH;

    localparam int STYLE_MAX = 550;
    localparam int SUM_MAX   = 4095;

    // corner order within the sum vector
    localparam int C00 = 0;
    localparam int C01 = 1;
    localparam int C10 = 2;
    localparam int C11 = 3;

    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [FRAC_W-1:0]  frac_t;

    typedef struct packed {
        logic take;
        logic add_en;
        logic clear;
    } lane_ctl_t;

    // a + floor((b - a) * f / 16); result stays between a and b
    function automatic sum_t lerp_step(sum_t a, sum_t b, frac_t f);
        logic signed [SUM_W:0]          diff;
        logic signed [FRAC_W:0]         fx;
        logic signed [SUM_W+FRAC_W+1:0] prod;
        logic signed [SUM_W+FRAC_W+1:0] prod_sh;
        logic signed [SUM_W+1:0]        r;
        diff    = $signed({1'b0, b}) - $signed({1'b0, a});
        fx      = $signed({1'b0, f});
        prod    = diff * fx;
        prod_sh = prod >>> FRAC_W;
        r       = $signed({2'b00, a}) + prod_sh[SUM_W+1:0];
        return r[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/core/lbs_lane.sv =====
// ----------------------------------------------------------------------------
// Lightmap sampler lane
// One corner/channel accumulator: scales the texel channel by the style
// level and adds it with saturation.
// ----------------------------------------------------------------------------
`include "lightmap_bilinear_sampler_core_macros.svh"

module lbs_lane (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lbs_pkg::lane_ctl_t                ctl,
    input  logic [lbs_pkg::CH_W-1:0]          chan,
    input  logic [lbs_pkg::STYLE_W-1:0]       style,
    output lbs_pkg::sum_t                     sum_upd
);
    import lbs_pkg::*;

    localparam int PROD_W = CH_W + STYLE_W;
    localparam int ADD_W  = PROD_W - 8;

    sum_t              sum_reg;
    sum_t              sum_next;
    logic [PROD_W-1:0] prod;
    logic [ADD_W-1:0]  add;
    logic [SUM_W:0]    sum_wide;

    always_comb begin
        prod     = PROD_W'(chan) * PROD_W'(style);
        add      = prod[PROD_W-1:8];
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(add);
        if (!ctl.add_en) begin
            sum_upd = sum_reg;
        end else if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
            sum_upd = SUM_W'(SUM_MAX);
        end else begin
            sum_upd = sum_wide[SUM_W-1:0];
        end
        sum_next = sum_reg;
        if (ctl.take) begin
            sum_next = ctl.clear ? '0 : sum_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    `LBS_ASSERT_NEXT(a_lane_clear, aclk, aresetn, ctl.take && ctl.clear, sum_reg == '0)
    `LBS_ASSERT_NEXT(a_lane_hold, aclk, aresetn, !ctl.take, sum_reg == $past(sum_reg))
    `LBS_ASSERT_NEXT(a_lane_mono, aclk, aresetn, ctl.take && !ctl.clear,
                     sum_reg >= $past(sum_reg))

endmodule

// ===== rtl/core/lbs_lerp.sv =====
// ----------------------------------------------------------------------------
// Lightmap sampler interpolator
// Merges the corner sums of all lanes: captures them, interpolates along s,
// then along t, and holds the RGB result for the output channel.
// ----------------------------------------------------------------------------
`include "lightmap_bilinear_sampler_core_macros.svh"

module lbs_lerp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load,
    output logic                                  load_ready,
    input  lbs_pkg::sum_t [lbs_pkg::NUM_SUMS-1:0] sums_in,
    input  lbs_pkg::frac_t                        fs_in,
    input  lbs_pkg::frac_t                        ft_in,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output lbs_pkg::level_t                       m_red_level,
    output lbs_pkg::level_t                       m_green_level,
    output lbs_pkg::level_t                       m_blue_level
);
    import lbs_pkg::*;

    logic                       snap_valid_reg;
    sum_t [NUM_SUMS-1:0]        snap_sums_reg;
    frac_t                      snap_fs_reg;
    frac_t                      snap_ft_reg;

    logic                       mid_valid_reg;
    sum_t [NUM_CH-1:0]          mid_top_reg;
    sum_t [NUM_CH-1:0]          mid_bot_reg;
    frac_t                      mid_ft_reg;

    logic                       out_valid_reg;
    level_t [NUM_CH-1:0]        out_reg;

    logic out_ready;
    logic mid_ready;
    logic snap_ready;
    logic mid_adv;
    logic snap_adv;

    always_comb begin
        out_ready  = !out_valid_reg || m_ready;
        mid_adv    = mid_valid_reg && out_ready;
        mid_ready  = !mid_valid_reg || out_ready;
        snap_adv   = snap_valid_reg && mid_ready;
        snap_ready = !snap_valid_reg || mid_ready;
        load_ready = snap_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
            mid_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (snap_ready) begin
                snap_valid_reg <= load;
            end
            if (mid_ready) begin
                mid_valid_reg <= snap_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && snap_ready) begin
            snap_sums_reg <= sums_in;
            snap_fs_reg   <= fs_in;
            snap_ft_reg   <= ft_in;
        end
        if (snap_adv) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                mid_top_reg[ch] <= lerp_step(snap_sums_reg[C00*NUM_CH+ch],
                                             snap_sums_reg[C01*NUM_CH+ch], snap_fs_reg);
                mid_bot_reg[ch] <= lerp_step(snap_sums_reg[C10*NUM_CH+ch],
                                             snap_sums_reg[C11*NUM_CH+ch], snap_fs_reg);
            end
            mid_ft_reg <= snap_ft_reg;
        end
        if (mid_adv) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                out_reg[ch] <= LEVEL_W'(lerp_step(mid_top_reg[ch], mid_bot_reg[ch],
                                                  mid_ft_reg));
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_red_level   = out_reg[0];
    assign m_green_level = out_reg[1];
    assign m_blue_level  = out_reg[2];

    `LBS_ASSERT_NEXT(a_load_capt, aclk, aresetn, load && load_ready, snap_valid_reg)
    `LBS_ASSERT_NEXT(a_snap_to_mid, aclk, aresetn, snap_valid_reg && mid_ready, mid_valid_reg)
    `LBS_ASSERT_NEXT(a_mid_to_out, aclk, aresetn, mid_valid_reg && out_ready, out_valid_reg)

endmodule

// ===== rtl/core/lightmap_bilinear_sampler_core.sv =====
// ----------------------------------------------------------------------------
// Lightmap bilinear sampler core
// Accumulates style-scaled RGB texels of the four corners of a sample point
// over its light-style layers, then interpolates them bilinearly.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transfer per light-style layer (four RGB texels, style
//   level, s/t fractions, last-layer flag). Twelve lanes scale and add one
//   corner channel each, so a layer is taken every cycle while s_ready is high.
//   m_* channel: one RGB transfer for each layer flagged last.
//   Result path: the last layer's sums are captured into the snapshot
//   register at its transfer, interpolated along s into the mid register,
//   then along t into the output register. Throughput: 1 layer per cycle
//   while s_ready is high, set by the lane multiply-accumulate.
//   Layers beyond MAX_LAYERS for one point add nothing; styles above 550
//   are clamped; each sum saturates at 4095.
//   Stall: the interpolator holds up to three points; once all three stages
//   are full and m_ready is low, s_ready drops until the receiver drains.
//   Reset: synchronous, active low; clears sums, layer count and all valid
//   flags. No results are pending after reset.
// ----------------------------------------------------------------------------
`include "lightmap_bilinear_sampler_core_macros.svh"

module lightmap_bilinear_sampler_core #(
    parameter int MAX_LAYERS = lbs_pkg::MAX_LAYERS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lbs_pkg::TEXEL_W-1:0]        s_texel_00,
    input  logic [lbs_pkg::TEXEL_W-1:0]        s_texel_01,
    input  logic [lbs_pkg::TEXEL_W-1:0]        s_texel_10,
    input  logic [lbs_pkg::TEXEL_W-1:0]        s_texel_11,
    input  logic [lbs_pkg::STYLE_W-1:0]        s_style_level,
    input  lbs_pkg::frac_t                     s_s_fraction,
    input  lbs_pkg::frac_t                     s_t_fraction,
    input  logic                               s_last_layer,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lbs_pkg::level_t                    m_red_level,
    output lbs_pkg::level_t                    m_green_level,
    output lbs_pkg::level_t                    m_blue_level
);
    import lbs_pkg::*;

    localparam int CNT_W = $clog2(MAX_LAYERS + 1);

    logic [CNT_W-1:0]                      cnt_reg;
    logic [CNT_W-1:0]                      cnt_next;
    logic                                  accept;
    logic [STYLE_W-1:0]                    style_clamped;
    lane_ctl_t                             lane_ctl;
    logic [NUM_CORNERS-1:0][TEXEL_W-1:0]   texels;
    sum_t [NUM_SUMS-1:0]                   sums_upd;

    assign texels = {s_texel_11, s_texel_10, s_texel_01, s_texel_00};
    assign accept = s_valid && s_ready;

    always_comb begin
        style_clamped = (s_style_level > STYLE_W'(STYLE_MAX)) ? STYLE_W'(STYLE_MAX)
                                                               : s_style_level;
        lane_ctl.take   = accept;
        lane_ctl.add_en = cnt_reg < CNT_W'(MAX_LAYERS);
        lane_ctl.clear  = s_last_layer;
        cnt_next = cnt_reg;
        if (accept) begin
            if (s_last_layer) begin
                cnt_next = '0;
            end else if (lane_ctl.add_en) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
        for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
            lbs_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (lane_ctl),
                .chan    (texels[c][CH_W*ch +: CH_W]),
                .style   (style_clamped),
                .sum_upd (sums_upd[c*NUM_CH+ch])
            );
        end
    end

    lbs_lerp u_lerp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (s_valid && s_last_layer),
        .load_ready    (s_ready),
        .sums_in       (sums_upd),
        .fs_in         (s_s_fraction),
        .ft_in         (s_t_fraction),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level)
    );

    `LBS_ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_LAYERS))
    `LBS_ASSERT_NEXT(a_cnt_clear, aclk, aresetn, accept && s_last_layer, cnt_reg == '0)
    `LBS_ASSERT_NEXT(a_cnt_step, aclk, aresetn,
                     accept && !s_last_layer && (cnt_reg < CNT_W'(MAX_LAYERS)),
                     cnt_reg == $past(cnt_reg) + CNT_W'(1))

endmodule

// ===== tb/sv/lightmap_bilinear_sampler_core_tb.sv =====
// ----------------------------------------------------------------------------
// Lightmap bilinear sampler core testbench
// Drives light-style layers into the sampler and checks every RGB transfer against an
// in-bench accumulate-and-interpolate predictor or, for known directed rows, their table
// values. A short directed table comes first, then random sample points over four handshake
// idling phases, a long receiver hold-off in the first phase, and drain pauses between phases.
// ----------------------------------------------------------------------------
module lightmap_bilinear_sampler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbs_pkg::*;

    localparam int ITEMS_PER_PHASE = 212;
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 10;
    localparam logic [TEXEL_W-1:0] WHITE = 24'hFFFFFF;

    typedef struct packed {
        logic [TEXEL_W-1:0] t00;
        logic [TEXEL_W-1:0] t01;
        logic [TEXEL_W-1:0] t10;
        logic [TEXEL_W-1:0] t11;
        logic [STYLE_W-1:0] style;
        frac_t              fs;
        frac_t              ft;
        logic               last_layer;
        logic               known;
        level_t             red;
        level_t             green;
        level_t             blue;
    } layer_row_t;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } rgb_t;

    localparam int NUM_DIRECTED = 20;
    localparam layer_row_t DIRECTED [NUM_DIRECTED] = '{
        '{24'h0, 24'h0, 24'h0, 24'h0, 10'd0, 4'd0, 4'd0, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0},
        '{WHITE, WHITE, WHITE, WHITE, 10'd256, 4'd0, 4'd0, 1'b1, 1'b1,
          12'd255, 12'd255, 12'd255},
        '{WHITE, WHITE, WHITE, WHITE, 10'd1023, 4'd15, 4'd15, 1'b1, 1'b1,
          12'd547, 12'd547, 12'd547},
        '{WHITE, WHITE, WHITE, WHITE, 10'd550, 4'd15, 4'd15, 1'b1, 1'b1,
          12'd547, 12'd547, 12'd547},
        '{24'h010203, 24'hFF80FF, 24'h7F7F7F, 24'h000080, 10'd551, 4'd9, 4'd6, 1'b1, 1'b0,
          12'd0, 12'd0, 12'd0},
        // layers beyond the limit add nothing; fractions come from the last layer
        '{WHITE, WHITE, WHITE, WHITE, 10'd550, 4'd15, 4'd7, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
        '{WHITE, WHITE, WHITE, WHITE, 10'd550, 4'd15, 4'd7, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
        '{WHITE, WHITE, WHITE, WHITE, 10'd550, 4'd15, 4'd7, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
        '{WHITE, WHITE, WHITE, WHITE, 10'd550, 4'd15, 4'd7, 1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
        '{WHITE, WHITE, WHITE, WHITE, 10'd550, 4'd0, 4'd0, 1'b1, 1'b1,
          12'd2188, 12'd2188, 12'd2188},
        '{WHITE, 24'h0, 24'h0, 24'h0, 10'd256, 4'd15, 4'd0, 1'b1, 1'b0, 12'd0, 12'd0, 12'd0},
        '{24'h0, WHITE, 24'h0, 24'h0, 10'd256, 4'd15, 4'd15, 1'b1, 1'b0, 12'd0, 12'd0, 12'd0},
        '{24'h0, 24'h0, 24'h00FF00, 24'h0, 10'd256, 4'd8, 4'd15, 1'b1, 1'b0,
          12'd0, 12'd0, 12'd0},
        '{WHITE, 24'h0, 24'h0, 24'hFF0000, 10'd256, 4'd1, 4'd1, 1'b1, 1'b0,
          12'd0, 12'd0, 12'd0},
        '{24'h123456, 24'hABCDEF, 24'h00FF00, 24'hFF00FF, 10'd300, 4'd5, 4'd10, 1'b0, 1'b0,
          12'd0, 12'd0, 12'd0},
        '{24'h123456, 24'hABCDEF, 24'h00FF00, 24'hFF00FF, 10'd300, 4'd3, 4'd12, 1'b1, 1'b0,
          12'd0, 12'd0, 12'd0},
        '{WHITE, WHITE, WHITE, WHITE, 10'd1, 4'd7, 4'd7, 1'b1, 1'b1, 12'd0, 12'd0, 12'd0},
        '{24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 10'h2AA, 4'hA, 4'h5, 1'b0, 1'b0,
          12'd0, 12'd0, 12'd0},
        '{24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 10'h155, 4'h5, 4'hA, 1'b1, 1'b0,
          12'd0, 12'd0, 12'd0},
        '{24'h0, WHITE, WHITE, 24'h0, 10'd512, 4'd15, 4'd15, 1'b1, 1'b0, 12'd0, 12'd0, 12'd0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [TEXEL_W-1:0]   s_texel_00 = '0;
    logic [TEXEL_W-1:0]   s_texel_01 = '0;
    logic [TEXEL_W-1:0]   s_texel_10 = '0;
    logic [TEXEL_W-1:0]   s_texel_11 = '0;
    logic [STYLE_W-1:0]   s_style_level = '0;
    frac_t                s_s_fraction = '0;
    frac_t                s_t_fraction = '0;
    logic                 s_last_layer = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    level_t               m_red_level;
    level_t               m_green_level;
    level_t               m_blue_level;

    sum_t corner_sums [NUM_SUMS];
    int   layers_taken = 0;
    rgb_t pending_rgb [$];
    int   error_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    lightmap_bilinear_sampler_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_texel_00    (s_texel_00),
        .s_texel_01    (s_texel_01),
        .s_texel_10    (s_texel_10),
        .s_texel_11    (s_texel_11),
        .s_style_level (s_style_level),
        .s_s_fraction  (s_s_fraction),
        .s_t_fraction  (s_t_fraction),
        .s_last_layer  (s_last_layer),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int lerp_sixteenth(int a, int b, int f);
        return a + (((b - a) * f) >>> 4);
    endfunction

    task automatic accumulate_layer(input layer_row_t l, output bit emits, output rgb_t rgb);
        logic [TEXEL_W-1:0] tex [NUM_CORNERS];
        level_t             lv [NUM_CH];
        int                 style;
        int                 total;
        int                 top;
        int                 bot;
        int                 v;
        tex = '{l.t00, l.t01, l.t10, l.t11};
        style = (int'(l.style) > STYLE_MAX) ? STYLE_MAX : int'(l.style);
        if (layers_taken < MAX_LAYERS_DEF) begin
            for (int c = 0; c < NUM_CORNERS; c++) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    total = int'(corner_sums[c*NUM_CH+ch])
                          + ((int'(tex[c][8*ch +: 8]) * style) >>> 8);
                    corner_sums[c*NUM_CH+ch] = sum_t'((total > SUM_MAX) ? SUM_MAX : total);
                end
            end
            layers_taken++;
        end
        emits = l.last_layer;
        rgb = '0;
        if (l.last_layer) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                top = lerp_sixteenth(int'(corner_sums[C00*NUM_CH+ch]),
                                     int'(corner_sums[C01*NUM_CH+ch]), int'(l.fs));
                bot = lerp_sixteenth(int'(corner_sums[C10*NUM_CH+ch]),
                                     int'(corner_sums[C11*NUM_CH+ch]), int'(l.fs));
                v = lerp_sixteenth(top, bot, int'(l.ft));
                lv[ch] = (v < 0) ? '0 : level_t'(v);
            end
            rgb = '{lv[0], lv[1], lv[2]};
            foreach (corner_sums[i]) corner_sums[i] = '0;
            layers_taken = 0;
        end
    endtask

    task automatic send_layer(input layer_row_t l);
        bit   emits;
        rgb_t rgb;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_texel_00    <= l.t00;
        s_texel_01    <= l.t01;
        s_texel_10    <= l.t10;
        s_texel_11    <= l.t11;
        s_style_level <= l.style;
        s_s_fraction  <= l.fs;
        s_t_fraction  <= l.ft;
        s_last_layer  <= l.last_layer;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        accumulate_layer(l, emits, rgb);
        if (emits) begin
            if (l.known) begin
                rgb = '{l.red, l.green, l.blue};
            end
            pending_rgb.push_back(rgb);
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rgb.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [TEXEL_W-1:0] rand_texel();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return WHITE;
        return TEXEL_W'($urandom);
    endfunction

    function automatic layer_row_t rand_layer(bit last_layer);
        layer_row_t l;
        l = '0;
        l.t00 = rand_texel();
        l.t01 = rand_texel();
        l.t10 = rand_texel();
        l.t11 = rand_texel();
        if ($urandom_range(0, 9) == 0) begin
            l.style = STYLE_W'($urandom);
        end else begin
            l.style = STYLE_W'($urandom_range(0, STYLE_MAX));
        end
        l.fs = FRAC_W'($urandom);
        l.ft = FRAC_W'($urandom);
        l.last_layer = last_layer;
        return l;
    endfunction

    task automatic check_field(input string name, input level_t expd, input level_t act);
        if (expd !== act) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expd, act);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        rgb_t expd;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual %0d %0d %0d",
                         $time, m_red_level, m_green_level, m_blue_level);
                error_count++;
            end else begin
                expd = pending_rgb.pop_front();
                check_field("red", expd.red, m_red_level);
                check_field("green", expd.green, m_green_level);
                check_field("blue", expd.blue, m_blue_level);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int sent;
        int layers;
        foreach (corner_sums[i]) corner_sums[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) send_layer(DIRECTED[i]);
        wait_drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if (phase == 0 && sent >= 40 && sent < 47) begin
                    hold_req = 1'b1;
                end
                if ($urandom_range(0, 9) == 0) begin
                    // stray layers with no closing item of their own
                    layers = $urandom_range(1, 3);
                    for (int k = 0; k < layers; k++) send_layer(rand_layer(1'b0));
                end else begin
                    layers = $urandom_range(1, 6);
                    for (int k = 0; k < layers; k++) begin
                        send_layer(rand_layer(k == layers - 1));
                    end
                end
                sent += layers;
            end
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
